>>> rtl/core/gpq_pkg.sv
// Package with the types, codes and defaults of the grouped print queue.
`timescale 1ns / 1ps

package gpq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_REMOVED  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic        action;
      logic [7:0]  user_key;
      logic [15:0] job_id;
      logic [15:0] file_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_user_key;
      logic [15:0] out_job_id;
      logic [15:0] out_file_handle;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  user;
      logic [15:0] job;
      logic [15:0] handle;
   } entry_type;

   typedef struct packed {
      logic take_right;
      logic load_new;
      logic take_left;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_APPLY   = 3'b100
   } state_type;

endpackage

>>> rtl/core/gpq_cell.sv
// One queue cell: holds a job entry, compares its key and loads a new entry or one from its neighbors.
`timescale 1ns / 1ps

module gpq_cell (
   input  logic                  clock,
   input  gpq_pkg::cell_ctl_type ctl,
   input  gpq_pkg::entry_type    new_entry,
   input  gpq_pkg::entry_type    left_entry,
   input  gpq_pkg::entry_type    right_entry,
   input  logic [7:0]            key,
   input  logic                  occupied,
   output gpq_pkg::entry_type    entry,
   output logic                  match
);
   import gpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      priority if (ctl.take_right) begin
         entry_in = right_entry;
      end else if (ctl.load_new) begin
         entry_in = new_entry;
      end else if (ctl.take_left) begin
         entry_in = left_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = occupied && (entry_ff.user == key);

endmodule

>>> rtl/core/grouped_print_queue.sv
// Top level of the grouped print queue: a chain of job cells and its sequencer.
`timescale 1ns / 1ps

// The grouped print queue keeps up to QUEUE_DEPTH jobs in order, with jobs of the
// same user key kept next to each other. A request is taken at a rising edge where
// start is high and busy is low. An insert places the job right after the last
// queued job with the same key, or at the tail when no job has that key; an insert
// into a full queue is dropped. A remove pops the head job and returns it.
// Every request gives one result on rsp_data, marked by rsp_valid for one cycle.
// The compare state compares the key in every cell at once and registers the
// match vector; the apply state shifts the chain and writes the result. Busy
// is high only in the compare state, so a new request can be taken in the apply
// state of the request before it. The receiver cannot stall and must take each
// result in the cycle it is shown. Reset empties the queue and drops any request
// in progress; no clearing pass is needed.

module grouped_print_queue #(
   parameter int QUEUE_DEPTH = gpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gpq_pkg::req_type req_data,
   output logic             rsp_valid,
   output gpq_pkg::rsp_type rsp_data
);
   import gpq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type                state_ff;
   state_type                state_in;
   req_type                  req_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [QUEUE_DEPTH-1:0]   match_ff;
   logic [QUEUE_DEPTH-1:0]   match_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;

   entry_type                entry_q   [QUEUE_DEPTH];
   entry_type                left_d    [QUEUE_DEPTH];
   entry_type                right_d   [QUEUE_DEPTH];
   cell_ctl_type             ctl       [QUEUE_DEPTH];
   entry_type                new_entry;
   logic [QUEUE_DEPTH-1:0]   occ_vec;
   logic [QUEUE_DEPTH-1:0]   tail_vec;
   logic [QUEUE_DEPTH-1:0]   ins_vec;
   logic [QUEUE_DEPTH-1:0]   ahead_vec;
   logic                     accept;
   logic                     found;
   logic                     full;
   logic                     empty;
   logic                     do_ins;
   logic                     do_rem;

   assign busy   = (state_ff == ST_COMPARE);
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign found  = |match_ff;

   assign new_entry.user   = req_ff.user_key;
   assign new_entry.job    = req_ff.job_id;
   assign new_entry.handle = req_ff.file_handle;

   assign do_ins = (state_ff == ST_APPLY) && (req_ff.action == ACTION_INSERT) && !full;
   assign do_rem = (state_ff == ST_APPLY) && (req_ff.action == ACTION_REMOVE) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic cell_match;

      assign occ_vec[i]  = (count_ff > CW'(i));
      assign tail_vec[i] = (count_ff == CW'(i));

      if (i == 0) begin : g_first
         assign left_d[i]    = new_entry;
         assign ins_vec[i]   = found ? 1'b0 : tail_vec[i];
         assign ahead_vec[i] = 1'b0;
      end else begin : g_rest
         assign left_d[i]    = entry_q[i-1];
         assign ins_vec[i]   = found ? (match_ff[i-1] && !match_ff[i]) : tail_vec[i];
         assign ahead_vec[i] = |ins_vec[i-1:0];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_d[i] = entry_q[i];
      end else begin : g_inner
         assign right_d[i] = entry_q[i+1];
      end

      assign ctl[i].take_right = do_rem;
      assign ctl[i].load_new   = do_ins && ins_vec[i];
      assign ctl[i].take_left  = do_ins && ahead_vec[i];

      gpq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[i]),
         .new_entry   (new_entry),
         .left_entry  (left_d[i]),
         .right_entry (right_d[i]),
         .key         (req_ff.user_key),
         .occupied    (occ_vec[i]),
         .entry       (entry_q[i]),
         .match       (cell_match)
      );

      assign match_in[i] = cell_match;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in     = accept ? ST_COMPARE : ST_IDLE;
            rsp_valid_in = 1'b1;
            if (req_ff.action == ACTION_INSERT) begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status = STATUS_INSERTED;
                  count_in      = count_ff + CW'(1);
               end
            end else begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  rsp_in.status          = STATUS_REMOVED;
                  rsp_in.out_user_key    = entry_q[0].user;
                  rsp_in.out_job_id      = entry_q[0].job;
                  rsp_in.out_file_handle = entry_q[0].handle;
                  count_in               = count_ff - CW'(1);
               end
            end
            rsp_in.occupancy = 5'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      match_ff <= match_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/gpq_checker.sv
// Port-level checker for the grouped print queue and its bind to the top level.
`timescale 1ns / 1ps

module gpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input gpq_pkg::rsp_type rsp_data
);
   import gpq_pkg::*;

   logic accept;

   assign accept = start && !busy;

   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("A taken request did not raise busy.");

   assert property (@(posedge clock) disable iff (reset) busy |=> !busy)
      else $error("Busy stayed high for more than one cycle.");

   assert property (@(posedge clock) disable iff (reset) accept |-> ##3 rsp_valid)
      else $error("A request did not give its result at the third edge after it was taken.");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("Results were shown in two cycles in a row.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_REMOVED) |->
         (rsp_data.out_job_id == '0) && (rsp_data.out_user_key == '0))
      else $error("A result without a removed job carried job fields.");

endmodule

bind grouped_print_queue gpq_checker u_gpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> test/grouped_print_queue_test.sv
// Self-checking bench for the grouped print queue: directed request table, then random traffic.
`timescale 1ns / 1ps

module grouped_print_queue_test;
   import gpq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int RANDOM_REQUESTS = 650;
   localparam int PHASE_LENGTH = 50;

   typedef struct {
      req_type request;
      bit      typed;
      rsp_type result;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic    row_typed;
   rsp_type row_result;

   entry_type    job_slots [DEPTH];
   int           job_total;
   rsp_type      awaited_results [$];
   plan_row_type plan_rows [$];

   int mismatch_count;
   int request_count;
   int insert_count;
   int drop_count;
   int remove_count;
   int empty_count;
   int peak_total;

   grouped_print_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type predict_print_result(req_type request);
      rsp_type outcome;
      int      slot;
      outcome = '0;
      if (request.action == ACTION_INSERT) begin
         if (job_total >= DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            slot = job_total;
            for (int i = 0; i < job_total; i++) begin
               if (job_slots[i].user == request.user_key) slot = i + 1;
            end
            for (int i = job_total; i > slot; i--) job_slots[i] = job_slots[i - 1];
            job_slots[slot] = '{user: request.user_key, job: request.job_id,
                                handle: request.file_handle};
            job_total++;
            outcome.status = STATUS_INSERTED;
         end
      end else if (job_total == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         outcome.out_user_key    = job_slots[0].user;
         outcome.out_job_id      = job_slots[0].job;
         outcome.out_file_handle = job_slots[0].handle;
         for (int i = 0; i + 1 < job_total; i++) job_slots[i] = job_slots[i + 1];
         job_total--;
         outcome.status = STATUS_REMOVED;
      end
      outcome.occupancy = job_total[4:0];
      return outcome;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("Result error at %0t ns: %s is %0h, should be %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic add_plan_row(logic act, logic [7:0] key, logic [15:0] job,
                               logic [15:0] hdl, bit typed, rsp_type want);
      plan_row_type row;
      row.request = '{action: act, user_key: key, job_id: job, file_handle: hdl};
      row.typed   = typed;
      row.result  = want;
      plan_rows.push_back(row);
   endtask

   task automatic send_request(req_type request, bit typed, rsp_type want, int gap);
      if (gap > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start      <= 1'b1;
      req_data   <= request;
      row_typed  <= typed;
      row_result <= want;
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unrequested result, status", rsp_data.status, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.out_user_key !== want.out_user_key)
                  report_mismatch("user key", rsp_data.out_user_key, want.out_user_key);
               if (rsp_data.out_job_id !== want.out_job_id)
                  report_mismatch("job id", rsp_data.out_job_id, want.out_job_id);
               if (rsp_data.out_file_handle !== want.out_file_handle)
                  report_mismatch("file handle", rsp_data.out_file_handle,
                                  want.out_file_handle);
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch("occupancy", rsp_data.occupancy, want.occupancy);
            end
         end
         if (start && !busy) begin
            want = predict_print_result(req_data);
            request_count++;
            case (want.status)
               STATUS_INSERTED: insert_count++;
               STATUS_FULL:     drop_count++;
               STATUS_REMOVED:  remove_count++;
               default:         empty_count++;
            endcase
            if (job_total > peak_total) peak_total = job_total;
            awaited_results.push_back(row_typed ? row_result : want);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d results outstanding", awaited_results.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int      gap;
      int      insert_pct;
      bit      steady;
      req_type request;
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      row_typed      = 1'b0;
      row_result     = '0;
      job_total      = 0;
      mismatch_count = 0;
      request_count  = 0;
      insert_count   = 0;
      drop_count     = 0;
      remove_count   = 0;
      empty_count    = 0;
      peak_total     = 0;

      add_plan_row(ACTION_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b1,
                   '{STATUS_EMPTY, 8'h00, 16'h0000, 16'h0000, 5'd0});
      add_plan_row(ACTION_INSERT, 8'h00, 16'h0000, 16'h0000, 1'b1,
                   '{STATUS_INSERTED, 8'h00, 16'h0000, 16'h0000, 5'd1});
      add_plan_row(ACTION_INSERT, 8'hff, 16'hffff, 16'hffff, 1'b1,
                   '{STATUS_INSERTED, 8'h00, 16'h0000, 16'h0000, 5'd2});
      add_plan_row(ACTION_INSERT, 8'h00, 16'h0001, 16'h1111, 1'b1,
                   '{STATUS_INSERTED, 8'h00, 16'h0000, 16'h0000, 5'd3});
      add_plan_row(ACTION_REMOVE, 8'h55, 16'h5555, 16'haaaa, 1'b1,
                   '{STATUS_REMOVED, 8'h00, 16'h0000, 16'h0000, 5'd2});
      add_plan_row(ACTION_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b1,
                   '{STATUS_REMOVED, 8'h00, 16'h0001, 16'h1111, 5'd1});
      add_plan_row(ACTION_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b1,
                   '{STATUS_REMOVED, 8'hff, 16'hffff, 16'hffff, 5'd0});
      add_plan_row(ACTION_REMOVE, 8'hff, 16'hffff, 16'hffff, 1'b1,
                   '{STATUS_EMPTY, 8'h00, 16'h0000, 16'h0000, 5'd0});
      for (int i = 0; i < DEPTH; i++) begin
         add_plan_row(ACTION_INSERT, 8'h10 + 8'(i % 3), 16'h0100 + 16'(i), 16'ha000 + 16'(i),
                      1'b1, '{STATUS_INSERTED, 8'h00, 16'h0000, 16'h0000, 5'(i + 1)});
      end
      add_plan_row(ACTION_INSERT, 8'h42, 16'hbeef, 16'h1234, 1'b1,
                   '{STATUS_FULL, 8'h00, 16'h0000, 16'h0000, 5'(DEPTH)});
      add_plan_row(ACTION_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0);
      add_plan_row(ACTION_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (plan_rows[n]) begin
         send_request(plan_rows[n].request, plan_rows[n].typed, plan_rows[n].result,
                      $urandom_range(5));
      end

      insert_pct = 50;
      steady     = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % PHASE_LENGTH == 0) begin
            case ($urandom_range(3))
               0:       insert_pct = 20;
               1:       insert_pct = 50;
               2:       insert_pct = 80;
               default: insert_pct = 95;
            endcase
            steady = ($urandom_range(3) == 0);
         end
         request.action = ($urandom_range(99) < insert_pct) ? ACTION_INSERT : ACTION_REMOVE;
         request.user_key = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(5));
         request.job_id      = 16'($urandom_range(65535));
         request.file_handle = 16'($urandom_range(65535));
         gap = steady ? 0 : $urandom_range(5);
         send_request(request, 1'b0, '0, gap);
      end

      @(negedge clock) start <= 1'b0;
      for (int w = 0; w < 100 && awaited_results.size() != 0; w++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch("results never delivered, count", awaited_results.size(), 0);

      $display("Covered %0d requests: %0d inserted, %0d dropped while full, %0d removed, %0d empty.",
               request_count, insert_count, drop_count, remove_count, empty_count);
      $display("Queue reached %0d of %0d entries.", peak_total, DEPTH);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/gpq_pkg.sv
rtl/core/gpq_cell.sv
rtl/core/grouped_print_queue.sv
rtl/core/gpq_checker.sv
test/grouped_print_queue_test.sv
